// ===== hdl/hmmd_pkg.sv =====
// hmmd_pkg: shared types and constants for the handheld memory map decoder
// used by hmmd_ctrl, hmmd_datapath and handheld_memory_map_decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hmmd_pkg;

  // default number of tiles in one video RAM bank
  localparam int TILES_IN_BANK_DEF = 384;

  // store geometry
  localparam int VRAM_DEPTH = 16384;
  localparam int WRAM_DEPTH = 4096;
  localparam int OAM_DEPTH  = 160;
  localparam int HRAM_DEPTH = 127;
  localparam int CLR_W      = 14;   // clear counter covers the largest store

  // route codes
  localparam logic [1:0] ROUTE_INTERNAL = 2'd0;
  localparam logic [1:0] ROUTE_CART     = 2'd1;
  localparam logic [1:0] ROUTE_IO       = 2'd2;
  localparam logic [1:0] ROUTE_DROP     = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_VRAM_BANK      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CART_ATTACHED  = 1'd1;

  // access kind
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [7:0] OPEN_BUS_BYTE = 8'hFF;

  // commands from controller to datapath
  typedef struct packed {
    logic clr_en;   // write zeros at the clear counter
    logic acc_en;   // input transfer: decode and access stores
    logic load;     // move the access result into the output register
  } hmmd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;  // clear counter at its final entry
  } hmmd_status_t;

endpackage

`default_nettype wire

// ===== hdl/hmmd_ctrl.sv =====
// hmmd_ctrl: sequencing state machine for the memory map decoder
// clearing pass, input handshake, output valid; depends on hmmd_pkg
`timescale 1ns / 1ps
`default_nettype none

module hmmd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  input  wire hmmd_pkg::hmmd_status_t status,
  output hmmd_pkg::hmmd_cmd_t        cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUSY
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   load;

  // handshake decisions
  always_comb begin
    s_tready   = (state == ST_IDLE);
    accept     = s_tvalid && s_tready;
    load       = (state == ST_BUSY) && (!m_tvalid || m_tready);
    cmd.clr_en = (state == ST_CLEAR);
    cmd.acc_en = accept;
    cmd.load   = load;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (status.clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_BUSY;
      ST_BUSY:  if (load) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hmmd_datapath.sv =====
// hmmd_datapath: address decode, internal stores, config registers, output register
// driven by hmmd_ctrl commands; depends on hmmd_pkg
`timescale 1ns / 1ps
`default_nettype none

module hmmd_datapath #(
  parameter int TILES_IN_BANK = hmmd_pkg::TILES_IN_BANK_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire hmmd_pkg::hmmd_cmd_t            cmd,
  output hmmd_pkg::hmmd_status_t              status,
  input  wire logic                           req_type,
  input  wire logic [15:0]                    address,
  input  wire logic [7:0]                     write_data,
  input  wire logic                           cfg_we,
  input  wire logic [hmmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data,
  output logic [7:0]                          read_data,
  output logic [1:0]                          route,
  output logic [15:0]                         route_address,
  output logic                                tile_dirty,
  output logic [9:0]                          dirty_tile_index
);

  localparam int TILE_BYTES_RAW = TILES_IN_BANK * 16;
  localparam int TILE_BYTES     = (TILE_BYTES_RAW > 8192) ? 8192 : TILE_BYTES_RAW;

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_FF,
    SRC_VRAM,
    SRC_WLOW,
    SRC_WHIGH,
    SRC_OAM,
    SRC_HRAM,
    SRC_IE
  } src_t;

  // stores
  logic [7:0] vram  [hmmd_pkg::VRAM_DEPTH];
  logic [7:0] wlow  [hmmd_pkg::WRAM_DEPTH];
  logic [7:0] whigh [hmmd_pkg::WRAM_DEPTH];
  logic [7:0] oam   [hmmd_pkg::OAM_DEPTH];
  logic [7:0] hram  [hmmd_pkg::HRAM_DEPTH];
  logic [7:0] ie_byte;

  // config registers
  logic vram_bank;
  logic cartridge_attached;

  // clear counter
  logic [hmmd_pkg::CLR_W-1:0] clr_cnt;

  // decode results
  src_t        dec_src;
  logic [1:0]  dec_route;
  logic [15:0] dec_raddr;
  logic        dec_dirty;
  logic [9:0]  dec_tidx;
  logic        hit_vram, hit_wlow, hit_whigh, hit_oam, hit_hram, hit_ie;
  logic        wr;
  logic [10:0] tidx_sum;

  // store port signals
  logic [13:0] vram_a;
  logic [11:0] wram_a;
  logic [7:0]  oam_a;
  logic [6:0]  hram_a;
  logic [7:0]  wdata;
  logic        vram_we, wlow_we, whigh_we, oam_we, hram_we, ie_we;

  // registered access stage
  src_t        acc_src;
  logic [1:0]  acc_route;
  logic [15:0] acc_raddr;
  logic        acc_dirty;
  logic [9:0]  acc_tidx;
  logic [7:0]  vram_q, wlow_q, whigh_q, oam_q, hram_q, ie_q;
  logic [7:0]  sel_data;

  assign status.clr_last = &clr_cnt;
  assign wr = (req_type == hmmd_pkg::REQ_WRITE);

  // address decode
  always_comb begin
    dec_src   = SRC_ZERO;
    dec_route = hmmd_pkg::ROUTE_INTERNAL;
    dec_raddr = 16'd0;
    dec_dirty = 1'b0;
    dec_tidx  = 10'd0;
    hit_vram  = 1'b0;
    hit_wlow  = 1'b0;
    hit_whigh = 1'b0;
    hit_oam   = 1'b0;
    hit_hram  = 1'b0;
    hit_ie    = 1'b0;
    tidx_sum  = (vram_bank ? 11'(TILES_IN_BANK) : 11'd0) + 11'(address[12:4]);
    if (!address[15] || address[15:13] == 3'b101) begin
      // rom and external ram
      if (cartridge_attached) begin
        dec_route = hmmd_pkg::ROUTE_CART;
        dec_raddr = address;
      end else if (wr) begin
        dec_route = hmmd_pkg::ROUTE_DROP;
      end else begin
        dec_src = SRC_FF;
      end
    end else if (address[15:13] == 3'b100) begin
      hit_vram = 1'b1;
      dec_src  = SRC_VRAM;
      if (wr && {1'b0, address[12:0]} < 14'(TILE_BYTES)) begin
        dec_dirty = 1'b1;
        dec_tidx  = tidx_sum[9:0];
      end
    end else if (address < 16'hFE00) begin
      // work ram and its echo, bit 12 picks the bank in both
      if (address[12]) begin
        hit_whigh = 1'b1;
        dec_src   = SRC_WHIGH;
      end else begin
        hit_wlow = 1'b1;
        dec_src  = SRC_WLOW;
      end
    end else if (address < 16'hFEA0) begin
      hit_oam = 1'b1;
      dec_src = SRC_OAM;
    end else if (address < 16'hFF00) begin
      if (wr) dec_route = hmmd_pkg::ROUTE_DROP;
    end else if (address < 16'hFF80) begin
      dec_route = hmmd_pkg::ROUTE_IO;
      dec_raddr = address;
    end else if (address != 16'hFFFF) begin
      hit_hram = 1'b1;
      dec_src  = SRC_HRAM;
    end else begin
      hit_ie  = 1'b1;
      dec_src = SRC_IE;
    end
    // writes return no data
    if (wr) dec_src = SRC_ZERO;
  end

  // store ports: clearing pass or the accepted access
  always_comb begin
    if (cmd.clr_en) begin
      vram_a   = clr_cnt;
      wram_a   = clr_cnt[11:0];
      oam_a    = clr_cnt[7:0];
      hram_a   = clr_cnt[6:0];
      wdata    = 8'd0;
      vram_we  = 1'b1;
      wlow_we  = (clr_cnt < 14'(hmmd_pkg::WRAM_DEPTH));
      whigh_we = (clr_cnt < 14'(hmmd_pkg::WRAM_DEPTH));
      oam_we   = (clr_cnt < 14'(hmmd_pkg::OAM_DEPTH));
      hram_we  = (clr_cnt < 14'(hmmd_pkg::HRAM_DEPTH));
      ie_we    = 1'b0;
    end else begin
      vram_a   = {vram_bank, address[12:0]};
      wram_a   = address[11:0];
      oam_a    = address[7:0];
      hram_a   = address[6:0];
      wdata    = write_data;
      vram_we  = cmd.acc_en && wr && hit_vram;
      wlow_we  = cmd.acc_en && wr && hit_wlow;
      whigh_we = cmd.acc_en && wr && hit_whigh;
      oam_we   = cmd.acc_en && wr && hit_oam;
      hram_we  = cmd.acc_en && wr && hit_hram;
      ie_we    = cmd.acc_en && wr && hit_ie;
    end
  end

  // video ram
  always_ff @(posedge clk) begin
    if (vram_we) vram[vram_a] <= wdata;
    if (cmd.acc_en) vram_q <= vram[vram_a];
  end

  // work ram, low bank
  always_ff @(posedge clk) begin
    if (wlow_we) wlow[wram_a] <= wdata;
    if (cmd.acc_en) wlow_q <= wlow[wram_a];
  end

  // work ram, high bank
  always_ff @(posedge clk) begin
    if (whigh_we) whigh[wram_a] <= wdata;
    if (cmd.acc_en) whigh_q <= whigh[wram_a];
  end

  // sprite attribute ram
  always_ff @(posedge clk) begin
    if (oam_we) oam[oam_a] <= wdata;
    if (cmd.acc_en && hit_oam) oam_q <= oam[oam_a];
  end

  // high ram
  always_ff @(posedge clk) begin
    if (hram_we) hram[hram_a] <= wdata;
    if (cmd.acc_en && hit_hram) hram_q <= hram[hram_a];
  end

  // interrupt enable byte, config registers, clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      ie_byte            <= 8'd0;
      vram_bank          <= 1'b0;
      cartridge_attached <= 1'b0;
      clr_cnt            <= '0;
    end else begin
      if (ie_we) ie_byte <= wdata;
      if (cfg_we) begin
        unique case (cfg_index)
          hmmd_pkg::CFG_VRAM_BANK:     vram_bank <= cfg_data[0];
          hmmd_pkg::CFG_CART_ATTACHED: cartridge_attached <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.clr_en) clr_cnt <= clr_cnt + {{(hmmd_pkg::CLR_W-1){1'b0}}, 1'b1};
    end
  end

  // access stage registers
  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      acc_src   <= dec_src;
      acc_route <= dec_route;
      acc_raddr <= dec_raddr;
      acc_dirty <= dec_dirty;
      acc_tidx  <= dec_tidx;
      ie_q      <= ie_byte;
    end
  end

  // read data select
  always_comb begin
    unique case (acc_src)
      SRC_ZERO:  sel_data = 8'd0;
      SRC_FF:    sel_data = hmmd_pkg::OPEN_BUS_BYTE;
      SRC_VRAM:  sel_data = vram_q;
      SRC_WLOW:  sel_data = wlow_q;
      SRC_WHIGH: sel_data = whigh_q;
      SRC_OAM:   sel_data = oam_q;
      SRC_HRAM:  sel_data = hram_q;
      SRC_IE:    sel_data = ie_q;
      default:   sel_data = 8'd0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      read_data        <= sel_data;
      route            <= acc_route;
      route_address    <= acc_raddr;
      tile_dirty       <= acc_dirty;
      dirty_tile_index <= acc_tidx;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/handheld_memory_map_decoder.sv =====
// handheld_memory_map_decoder: top level of the 8-bit handheld memory map decoder
// instantiates hmmd_ctrl and hmmd_datapath; depends on hmmd_pkg
//
//   channel  direction  handshake             payload
//   s_axis   in         s_tvalid / s_tready   s_tuser req_type, s_tdata address, write_data
//   m_axis   out        m_tvalid / m_tready   m_tuser route, m_tdata result fields
//   cfg      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// each access passes the access stage registers, which hold the decode and the store read or
// write (registered read port), and then the output register; a new access is taken while the
// last result waits on m_tready, but the load stalls until the output register is free.
// after reset a clearing pass zeroes all stores, its length set by the video ram depth;
// s_tready stays low during it, configuration writes are taken at all times.
`timescale 1ns / 1ps
`default_nettype none

module handheld_memory_map_decoder #(
  parameter int TILES_IN_BANK = hmmd_pkg::TILES_IN_BANK_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [23:0]                    s_tdata,   // address, write_data
  input  wire logic                           s_tuser,   // req_type
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [39:0]                         m_tdata,   // read_data, route_address,
                                                         // tile_dirty, dirty_tile_index
  output logic [1:0]                          m_tuser,   // route
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [hmmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data
);

  hmmd_pkg::hmmd_cmd_t    cmd;
  hmmd_pkg::hmmd_status_t status;
  logic [7:0]             read_data;
  logic [15:0]            route_address;
  logic                   tile_dirty;
  logic [9:0]             dirty_tile_index;

  // config writes are always accepted and never stalled
  assign cfg_ready = 1'b1;

  // output packing
  assign m_tdata = {5'd0, dirty_tile_index, tile_dirty, route_address, read_data};

  hmmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  hmmd_datapath #(
    .TILES_IN_BANK (TILES_IN_BANK)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .req_type         (s_tuser),
    .address          (s_tdata[15:0]),
    .write_data       (s_tdata[23:16]),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .read_data        (read_data),
    .route            (m_tuser),
    .route_address    (route_address),
    .tile_dirty       (tile_dirty),
    .dirty_tile_index (dirty_tile_index)
  );

endmodule

`default_nettype wire
